// ===== hdl/rso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_pkg
// Shared constants for the rectangle overlap test (separating axis form).
// ----------------------------------------------------------------------------
package rso_pkg;

  // default coordinate width, signed Q10.6 at 16 bits
  localparam int COORD_WIDTH_DEF = 16;

  // corners per rectangle and coordinates per rectangle
  localparam int NUM_CORNERS = 4;
  localparam int NUM_COORDS  = 2 * NUM_CORNERS;

  // test axes: edges 0->1 and 1->2 of each rectangle
  localparam int NUM_AXES = 4;

  // configuration register index width
  localparam int CFG_ADDR_W = $clog2(NUM_COORDS);

endpackage

// ===== hdl/rso_axis_proj.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_axis_proj
// Projects the four corners of one rectangle onto an unnormalised axis by
// exact dot product.
// ----------------------------------------------------------------------------
module rso_axis_proj #(
  parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH:0]     ax,
  input  logic signed [COORD_WIDTH:0]     ay,
  input  logic signed [COORD_WIDTH-1:0]   rect [rso_pkg::NUM_COORDS],
  output logic signed [2*COORD_WIDTH+1:0] dot  [rso_pkg::NUM_CORNERS]
);

  localparam int PROD_W = 2 * COORD_WIDTH + 1;
  localparam int DOT_W  = 2 * COORD_WIDTH + 2;

  logic signed [PROD_W-1:0] px [rso_pkg::NUM_CORNERS];
  logic signed [PROD_W-1:0] py [rso_pkg::NUM_CORNERS];

  always_comb begin
    for (int c = 0; c < rso_pkg::NUM_CORNERS; c++) begin
      px[c]  = rect[2*c] * ax;
      py[c]  = rect[2*c+1] * ay;
      // full width sum, cannot overflow
      dot[c] = DOT_W'(px[c]) + DOT_W'(py[c]);
    end
  end

endmodule

// ===== hdl/rso_overlap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_overlap
// Builds the min/max projection intervals of both rectangles on one axis and
// tests them for overlap with inclusive bounds.
// ----------------------------------------------------------------------------
module rso_overlap #(
  parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [2*COORD_WIDTH+1:0] dot_a [rso_pkg::NUM_CORNERS],
  input  logic signed [2*COORD_WIDTH+1:0] dot_b [rso_pkg::NUM_CORNERS],
  output logic                            overlap
);

  localparam int DOT_W = 2 * COORD_WIDTH + 2;

  logic signed [DOT_W-1:0] a_min;
  logic signed [DOT_W-1:0] a_max;
  logic signed [DOT_W-1:0] b_min;
  logic signed [DOT_W-1:0] b_max;

  always_comb begin
    a_min = dot_a[0];
    a_max = dot_a[0];
    b_min = dot_b[0];
    b_max = dot_b[0];
    for (int c = 1; c < rso_pkg::NUM_CORNERS; c++) begin
      if (dot_a[c] < a_min) a_min = dot_a[c];
      if (dot_a[c] > a_max) a_max = dot_a[c];
      if (dot_b[c] < b_min) b_min = dot_b[c];
      if (dot_b[c] > b_max) b_max = dot_b[c];
    end
    // touching end points count as overlap
    overlap = ((b_min >= a_min) && (b_min <= a_max)) ||
              ((a_min >= b_min) && (a_min <= b_max));
  end

endmodule

// ===== hdl/rectangle_overlap_sat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_overlap_sat
// Separating axis overlap test of a candidate rectangle against a reference
// rectangle held in configuration registers.
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the output stalls, set by the
//   three-register pipeline (input register, dot product register,
//   result register)
// reset: synchronous, clears all valid flags and the reference corners to 0
module rectangle_overlap_sat #(
  parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // tdata: cand_x0, cand_y0, cand_x1, cand_y1, cand_x2, cand_y2, cand_x3, cand_y3
  input  logic [rso_pkg::NUM_COORDS*COORD_WIDTH-1:0] s_axis_tdata,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata: intersects, then zero fill
  output logic [7:0]                                 m_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  input  logic                                       cfg_we,
  input  logic [rso_pkg::CFG_ADDR_W-1:0]             cfg_addr,
  input  logic [COORD_WIDTH-1:0]                     cfg_wdata
);

  localparam int DOT_W = 2 * COORD_WIDTH + 2;
  localparam int NC    = rso_pkg::NUM_CORNERS;
  localparam int NA    = rso_pkg::NUM_AXES;

  logic signed [COORD_WIDTH-1:0] ref_c  [rso_pkg::NUM_COORDS];
  logic signed [COORD_WIDTH-1:0] s1_cand [rso_pkg::NUM_COORDS];
  logic                          s1_valid;
  logic                          s1_ready;

  logic signed [COORD_WIDTH:0]   ax [NA];
  logic signed [COORD_WIDTH:0]   ay [NA];

  logic signed [DOT_W-1:0] dot_ref_next  [NA][NC];
  logic signed [DOT_W-1:0] dot_cand_next [NA][NC];
  logic signed [DOT_W-1:0] s2_dot_ref    [NA][NC];
  logic signed [DOT_W-1:0] s2_dot_cand   [NA][NC];
  logic                    s2_valid;
  logic                    s2_ready;

  logic [NA-1:0] overlap;
  logic          out_free;

  // reference registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rso_pkg::NUM_COORDS; i++) ref_c[i] <= '0;
    end else if (cfg_we) begin
      ref_c[cfg_addr] <= cfg_wdata;
    end
  end

  // handshake chain, each stage moves when the next one frees up
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s2_ready      = !s2_valid || out_free;
  assign s1_ready      = !s1_valid || s2_ready;
  assign s_axis_tready = s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_axis_tvalid) begin
      for (int i = 0; i < rso_pkg::NUM_COORDS; i++)
        s1_cand[i] <= s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // axes: edges 0->1 and 1->2 of the reference, then of the candidate
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      ax[e]   = (COORD_WIDTH+1)'(ref_c[2*e+2]) - (COORD_WIDTH+1)'(ref_c[2*e]);
      ay[e]   = (COORD_WIDTH+1)'(ref_c[2*e+3]) - (COORD_WIDTH+1)'(ref_c[2*e+1]);
      ax[e+2] = (COORD_WIDTH+1)'(s1_cand[2*e+2]) - (COORD_WIDTH+1)'(s1_cand[2*e]);
      ay[e+2] = (COORD_WIDTH+1)'(s1_cand[2*e+3]) - (COORD_WIDTH+1)'(s1_cand[2*e+1]);
    end
  end

  for (genvar k = 0; k < NA; k++) begin : g_axis
    rso_axis_proj #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_proj_ref (
      .ax   (ax[k]),
      .ay   (ay[k]),
      .rect (ref_c),
      .dot  (dot_ref_next[k])
    );

    rso_axis_proj #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_proj_cand (
      .ax   (ax[k]),
      .ay   (ay[k]),
      .rect (s1_cand),
      .dot  (dot_cand_next[k])
    );

    rso_overlap #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_overlap (
      .dot_a   (s2_dot_ref[k]),
      .dot_b   (s2_dot_cand[k]),
      .overlap (overlap[k])
    );
  end

  // dot product register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_dot_ref  <= dot_ref_next;
      s2_dot_cand <= dot_cand_next;
    end
  end

  // result register, any separating axis clears the flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      m_axis_tdata <= {7'b0, &overlap};
    end
  end

`ifndef SYNTHESIS
  a_empty_stage_takes_item : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_axis_tready)
    else $error("input register empty but item refused");

  a_full_pipe_stalls : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("item accepted into a full stalled pipeline");

  a_stage_to_output : assert property (@(posedge clk) disable iff (rst)
    (s2_valid && out_free) |=> m_axis_tvalid)
    else $error("dot product stage advanced but no result shown");

  a_reset_clears : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!m_axis_tvalid && !s2_valid && !s1_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
